// File: src/ultrasonic_range_filter_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic range filter assertion macros
// Concurrent checks sampled on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_FILTER_MACROS_SVH
`define ULTRASONIC_RANGE_FILTER_MACROS_SVH

// same-cycle implication
`define URF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ultrasonic_range_filter: assertion failed");

// next-cycle implication
`define URF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ultrasonic_range_filter: assertion failed");

`endif

// File: src/urf_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic range filter package
// Widths, register map, reset values and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package urf_pkg;

  localparam int WINDOW_LEN_DEF = 20;

  localparam int PULSE_W = 24;
  localparam int DIST_W  = 16;
  localparam int SUM_W   = 21;
  localparam int NUM_W   = PULSE_W + 4;
  localparam int DIV_W   = 8;
  localparam int WGT_W   = 9;
  localparam int ACC_W   = DIST_W + WGT_W;
  localparam int CNT_W   = 5;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 56;

  localparam logic [CNT_W-1:0] STEPS_DIST = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] STEPS_MEAN = CNT_W'(SUM_W);
  localparam logic [CNT_W-1:0] STEPS_MUL  = CNT_W'(WGT_W);

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(256);

  localparam logic [2:0] REG_DIVISOR = 3'd0;
  localparam logic [2:0] REG_MIN     = 3'd1;
  localparam logic [2:0] REG_MAX     = 3'd2;
  localparam logic [2:0] REG_NEAR    = 3'd3;
  localparam logic [2:0] REG_WEIGHT  = 3'd4;

  localparam logic [DIV_W-1:0]  RST_DIVISOR = DIV_W'(58);
  localparam logic [DIST_W-1:0] RST_MIN     = DIST_W'(32);
  localparam logic [DIST_W-1:0] RST_MAX     = DIST_W'(6400);
  localparam logic [DIST_W-1:0] RST_NEAR    = DIST_W'(480);
  localparam logic [WGT_W-1:0]  RST_WEIGHT  = WGT_W'(51);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DIST,
    ST_CHECK,
    ST_PUSH,
    ST_DIV_MEAN,
    ST_SELECT,
    ST_MUL,
    ST_MUL_DONE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: src/ultrasonic_range_filter.sv
// Sequence: an out-of-range reading passes distance division and range check
//   to the output; an in-range one adds window push and mean division, and
//   the EMA multiply once the EMA blends. Words are taken only in idle, paced by the
//   shared restoring divider (one quotient bit a cycle) and serial multiplier.
// Reset: asynchronous, active low; clears window sum, fill count, slot, EMA
//   and the output valid flag; the window store itself is not cleared.
// ----------------------------------------------------------------------------
// Ultrasonic range filter
// Pulse width to distance, range check, sliding window mean and EMA.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_filter #(
  parameter int WINDOW_LEN = urf_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: pulse_us[23:0]
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [urf_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tdata: distance_q4[15:0], mean_q4[31:16], ema_q4[47:32], object_near[48], zero
  // tuser: reading_valid[0]
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [urf_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output      logic                          m_axis_tuser,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [urf_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [urf_pkg::APB_W-1:0]     pwdata,
  output      logic [urf_pkg::APB_W-1:0]     prdata,
  output      logic                          pready
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLT = SLOT_W'(WINDOW_LEN - 1);

  localparam int NUM_W  = urf_pkg::NUM_W;
  localparam int DIV_W  = urf_pkg::DIV_W;
  localparam int DIST_W = urf_pkg::DIST_W;
  localparam int SUM_W  = urf_pkg::SUM_W;
  localparam int WGT_W  = urf_pkg::WGT_W;
  localparam int ACC_W  = urf_pkg::ACC_W;
  localparam int CNT_W  = urf_pkg::CNT_W;

  // configuration registers
  logic [DIV_W-1:0]  divisor_q;
  logic [DIST_W-1:0] min_q, max_q, near_q;
  logic [WGT_W-1:0]  weight_q;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  // controller
  urf_pkg::state_e state_q, state_d;
  logic            load_dist, div_step, do_check, do_push, do_select;
  logic            mul_step, mul_done, out_load;

  // serial divider
  logic [NUM_W-1:0] num_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [DIV_W:0]   trial;
  logic             q_bit;
  logic [CNT_W-1:0] cnt_q;

  // window and filter state
  logic [DIST_W-1:0] win_mem [WINDOW_LEN];
  logic [DIST_W-1:0] rd_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SLOT_W-1:0] slot_q;
  logic [DIST_W-1:0] ema_val_q;
  logic              seeded_q;

  // result and multiplier
  logic [DIST_W-1:0] dist_q, mean_q, ema_out_q;
  logic              rvalid_q, near_flag_q;
  logic [DIST_W-1:0] dist_sat, mean_sat;
  logic              in_range;
  logic [WGT_W-1:0]  w_clamp;
  logic [WGT_W-1:0]  wm_q, cm_q;
  logic [ACC_W-1:0]  acc_q;

  // output register
  logic                         m_valid_q;
  logic [urf_pkg::M_DATA_W-1:0] m_data_q;
  logic                         m_user_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= urf_pkg::RST_DIVISOR;
      min_q     <= urf_pkg::RST_MIN;
      max_q     <= urf_pkg::RST_MAX;
      near_q    <= urf_pkg::RST_NEAR;
      weight_q  <= urf_pkg::RST_WEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        urf_pkg::REG_DIVISOR: divisor_q <= pwdata[DIV_W-1:0];
        urf_pkg::REG_MIN:     min_q     <= pwdata[DIST_W-1:0];
        urf_pkg::REG_MAX:     max_q     <= pwdata[DIST_W-1:0];
        urf_pkg::REG_NEAR:    near_q    <= pwdata[DIST_W-1:0];
        urf_pkg::REG_WEIGHT:  weight_q  <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      urf_pkg::REG_DIVISOR: prdata = urf_pkg::APB_W'(divisor_q);
      urf_pkg::REG_MIN:     prdata = urf_pkg::APB_W'(min_q);
      urf_pkg::REG_MAX:     prdata = urf_pkg::APB_W'(max_q);
      urf_pkg::REG_NEAR:    prdata = urf_pkg::APB_W'(near_q);
      urf_pkg::REG_WEIGHT:  prdata = urf_pkg::APB_W'(weight_q);
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      urf_pkg::ST_IDLE:     if (s_axis_tvalid) state_d = urf_pkg::ST_DIV_DIST;
      urf_pkg::ST_DIV_DIST: if (cnt_q == CNT_W'(1)) state_d = urf_pkg::ST_CHECK;
      urf_pkg::ST_CHECK:    state_d = in_range ? urf_pkg::ST_PUSH : urf_pkg::ST_DONE;
      urf_pkg::ST_PUSH:     state_d = urf_pkg::ST_DIV_MEAN;
      urf_pkg::ST_DIV_MEAN: if (cnt_q == CNT_W'(1)) state_d = urf_pkg::ST_SELECT;
      urf_pkg::ST_SELECT: begin
        if (fill_q == FULL && seeded_q) state_d = urf_pkg::ST_MUL;
        else state_d = urf_pkg::ST_DONE;
      end
      urf_pkg::ST_MUL:      if (cnt_q == CNT_W'(1)) state_d = urf_pkg::ST_MUL_DONE;
      urf_pkg::ST_MUL_DONE: state_d = urf_pkg::ST_DONE;
      urf_pkg::ST_DONE:     if (!m_valid_q || m_axis_tready) state_d = urf_pkg::ST_IDLE;
      default:              state_d = urf_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_dist     = 1'b0;
    div_step      = 1'b0;
    do_check      = 1'b0;
    do_push       = 1'b0;
    do_select     = 1'b0;
    mul_step      = 1'b0;
    mul_done      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      urf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        load_dist     = s_axis_tvalid;
      end
      urf_pkg::ST_DIV_DIST: div_step  = 1'b1;
      urf_pkg::ST_CHECK:    do_check  = 1'b1;
      urf_pkg::ST_PUSH:     do_push   = 1'b1;
      urf_pkg::ST_DIV_MEAN: div_step  = 1'b1;
      urf_pkg::ST_SELECT:   do_select = 1'b1;
      urf_pkg::ST_MUL:      mul_step  = 1'b1;
      urf_pkg::ST_MUL_DONE: mul_done  = 1'b1;
      urf_pkg::ST_DONE:     out_load  = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // -------------------------------------------------------- serial divider
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign q_bit = (trial >= {1'b0, dvs_q});

  assign dist_sat = (|num_q[NUM_W-1:DIST_W]) ? '1 : num_q[DIST_W-1:0];
  assign mean_sat = (|num_q[SUM_W-1:DIST_W]) ? '1 : num_q[DIST_W-1:0];
  assign in_range = (dist_sat >= min_q) && (dist_sat <= max_q);

  always_comb begin
    if (fill_q == FULL) begin
      fill_d = fill_q;
      sum_d  = sum_q - SUM_W'(rd_q) + SUM_W'(dist_q);
    end else begin
      fill_d = fill_q + FILL_W'(1);
      sum_d  = sum_q + SUM_W'(dist_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_dist) begin
      cnt_q <= urf_pkg::STEPS_DIST;
    end else if (do_push) begin
      cnt_q <= urf_pkg::STEPS_MEAN;
    end else if (do_select) begin
      cnt_q <= urf_pkg::STEPS_MUL;
    end else if (div_step || mul_step) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_dist) begin
      num_q <= {s_axis_tdata[urf_pkg::PULSE_W-1:0], 4'b0000};
      rem_q <= '0;
      dvs_q <= divisor_q;
    end else if (do_push) begin
      num_q <= {sum_d, (NUM_W - SUM_W)'(0)};
      rem_q <= '0;
      dvs_q <= DIV_W'(fill_d);
    end else if (div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
    end
  end

  // ---------------------------------------------------------- window store
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      win_mem[slot_q] <= dist_q;
    end
    rd_q <= win_mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      slot_q <= '0;
    end else if (do_push) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      slot_q <= (slot_q == LAST_SLT) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  // ------------------------------------------------------------------- EMA
  assign w_clamp = (weight_q > urf_pkg::WGT_ONE) ? urf_pkg::WGT_ONE : weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_val_q <= '0;
      seeded_q  <= 1'b0;
    end else if (do_select && fill_q == FULL && !seeded_q) begin
      ema_val_q <= mean_sat;
      seeded_q  <= 1'b1;
    end else if (mul_done) begin
      ema_val_q <= acc_q[DIST_W+7:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_select) begin
      wm_q  <= w_clamp;
      cm_q  <= urf_pkg::WGT_ONE - w_clamp;
      acc_q <= '0;
    end else if (mul_step) begin
      wm_q  <= {wm_q[WGT_W-2:0], 1'b0};
      cm_q  <= {cm_q[WGT_W-2:0], 1'b0};
      acc_q <= {acc_q[ACC_W-2:0], 1'b0}
             + (wm_q[WGT_W-1] ? ACC_W'(dist_q) : '0)
             + (cm_q[WGT_W-1] ? ACC_W'(ema_val_q) : '0);
    end
  end

  // ------------------------------------------------------------- result
  always_ff @(posedge clk_i) begin
    if (do_check) begin
      dist_q      <= dist_sat;
      rvalid_q    <= in_range;
      near_flag_q <= in_range && (dist_sat < near_q);
      mean_q      <= '0;
      ema_out_q   <= '0;
    end else if (do_select) begin
      mean_q    <= mean_sat;
      ema_out_q <= mean_sat;
    end else if (mul_done) begin
      ema_out_q <= acc_q[DIST_W+7:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {7'b0000000, near_flag_q, ema_out_q, mean_q, dist_q};
      m_user_q <= rvalid_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ------------------------------------------------------------ assertions
`include "ultrasonic_range_filter_macros.svh"

  `URF_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FULL)
  `URF_ASSERT_IMPL(a_seed_full, seeded_q, fill_q == FULL)
  `URF_ASSERT_NEXT(a_accept_div, s_axis_tvalid && s_axis_tready, state_q == urf_pkg::ST_DIV_DIST)
  `URF_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[48:16] == '0)

endmodule

`default_nettype wire
